// ===== src/inae_pkg.sv =====
// Package for the incremental accumulator evaluator.
// Sizes, codes, state type and helpers shared by the interfaces, inae_mac and the top module.
// No dependencies.
package inae_pkg;

  localparam int NUM_FEATURES = 768;
  localparam int HIDDEN_SIZE  = 256;
  localparam int SCORE_SHIFT  = 14;

  localparam int MODE_W   = 3;
  localparam int FEAT_W   = 10;
  localparam int NEUR_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int ACC_W    = 32;
  localparam int SCORE_W  = 18;

  localparam int HID_AW   = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
  localparam int IW_DEPTH = NUM_FEATURES * HIDDEN_SIZE;
  localparam int IW_AW    = (IW_DEPTH > 1) ? $clog2(IW_DEPTH) : 1;

  typedef logic [MODE_W-1:0]          mode_w_t;
  typedef logic [FEAT_W-1:0]          feat_t;
  typedef logic [NEUR_W-1:0]          neur_t;
  typedef logic signed [WEIGHT_W-1:0] wgt_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SCORE_W-1:0]  score_t;
  typedef logic [HID_AW-1:0]          hid_addr_t;
  typedef logic [IW_AW-1:0]           iw_addr_t;

  localparam acc_t SCORE_ROUND = acc_t'((1 << SCORE_SHIFT) - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_IW = 3'd0,
    MODE_LOAD_HB = 3'd1,
    MODE_LOAD_OW = 3'd2,
    MODE_RESET   = 3'd3,
    MODE_ADD     = 3'd4,
    MODE_REMOVE  = 3'd5,
    MODE_EVAL    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctrl_t;

  function automatic acc_t sext_w(input wgt_t w);
    return acc_t'(w);
  endfunction

endpackage

// ===== src/inae_in_if.sv =====
// Input item channel of the incremental accumulator evaluator.
// Depends on inae_pkg for field widths.
interface inae_in_if;
  logic                 valid;
  logic                 ready;
  inae_pkg::mode_w_t    mode;
  inae_pkg::feat_t      feature_index;
  inae_pkg::neur_t      neuron_index;
  inae_pkg::wgt_t       weight_value;

  modport source(output valid, output mode, output feature_index,
                 output neuron_index, output weight_value, input ready);
  modport sink(input valid, input mode, input feature_index,
               input neuron_index, input weight_value, output ready);
endinterface

// ===== src/inae_out_if.sv =====
// Result channel of the incremental accumulator evaluator.
// Depends on inae_pkg for the score width.
interface inae_out_if;
  logic            valid;
  logic            ready;
  inae_pkg::score_t score;

  modport source(output valid, output score, input ready);
  modport sink(input valid, input score, output ready);
endinterface

// ===== src/inae_cfg_if.sv =====
// Configuration write channel carrying the output bias word.
// Depends on inae_pkg for the data width.
interface inae_cfg_if;
  logic           valid;
  logic           ready;
  inae_pkg::acc_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/inae_ram.sv =====
// Generic simple dual-port synchronous RAM, one write and one registered read.
// No dependencies.
module inae_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/inae_mac.sv =====
// Output multiply-accumulate for evaluation: ReLU, product register, running sum
// and score scaling. Depends on inae_pkg.
module inae_mac (
  input  logic                clk,
  input  logic                rst,
  input  inae_pkg::mac_ctrl_t ctrl,
  input  inae_pkg::acc_t      bias,
  input  inae_pkg::acc_t      acc,
  input  inae_pkg::wgt_t      weight,
  output inae_pkg::score_t    score
);

  logic                                      prod_vld;
  inae_pkg::acc_t                            prod;
  inae_pkg::acc_t                            sum;
  logic signed [inae_pkg::ACC_W+inae_pkg::WEIGHT_W-1:0] full;
  inae_pkg::acc_t                            adj;
  inae_pkg::acc_t                            shifted;

  assign full = acc * weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      prod <= acc[inae_pkg::ACC_W-1] ? '0 : full[inae_pkg::ACC_W-1:0];
    end
    if (ctrl.clear) begin
      sum <= bias;
    end else if (prod_vld) begin
      sum <= sum + prod;
    end
  end

  // truncate toward zero: bias negative sums up before the shift
  assign adj     = sum + (sum[inae_pkg::ACC_W-1] ? inae_pkg::SCORE_ROUND : '0);
  assign shifted = adj >>> inae_pkg::SCORE_SHIFT;
  assign score   = shifted[inae_pkg::SCORE_W-1:0];

endmodule

// ===== src/incremental_nn_accumulator_eval.sv =====
// Incremental hidden-layer accumulator with network evaluation. Load items
// write a weight store directly. Reset and evaluate items, and add and remove
// items with an in-range feature index, sweep all HIDDEN_SIZE neurons, one
// accumulator entry per cycle through the accumulator memory's single read and
// write port, and return to idle before the next item is taken.
// An evaluate item holds in its last step while an earlier score still waits on
// the result channel. The accumulator reads as zero after reset through per-entry
// valid bits, so no clearing pass is needed. Depends on inae_pkg, the channel
// interfaces, inae_ram and inae_mac.
module incremental_nn_accumulator_eval (
  input  logic    clk,
  input  logic    rst,
  inae_in_if.sink    items,
  inae_out_if.source results,
  inae_cfg_if.sink   cfg
);

  inae_pkg::state_t    state, state_next;
  inae_pkg::mode_w_t   op;
  inae_pkg::iw_addr_t  base;
  inae_pkg::hid_addr_t n;
  logic                s1_valid;
  inae_pkg::hid_addr_t s1_n;
  logic                s1_acc_vld;
  logic [inae_pkg::HIDDEN_SIZE-1:0] acc_vld;
  inae_pkg::acc_t      out_bias;
  logic                out_vld;
  inae_pkg::score_t    out_score;

  logic                accept;
  logic                feat_ok;
  logic                neur_ok;
  logic                rd_en;
  logic                out_load;
  logic                iw_we, hb_we, ow_we;
  inae_pkg::iw_addr_t  iw_waddr;
  inae_pkg::wgt_t      iw_rdata, hb_rdata, ow_rdata;
  logic                acc_we;
  inae_pkg::acc_t      acc_wdata, acc_rdata, acc_cur;
  inae_pkg::mac_ctrl_t mac_ctrl;
  inae_pkg::score_t    mac_score;

  assign accept  = items.valid && items.ready;
  assign feat_ok = items.feature_index < inae_pkg::NUM_FEATURES;
  assign neur_ok = items.neuron_index < inae_pkg::HIDDEN_SIZE;

  assign iw_we    = accept && items.mode == inae_pkg::MODE_LOAD_IW && feat_ok && neur_ok;
  assign hb_we    = accept && items.mode == inae_pkg::MODE_LOAD_HB && neur_ok;
  assign ow_we    = accept && items.mode == inae_pkg::MODE_LOAD_OW && neur_ok;
  assign iw_waddr = inae_pkg::iw_addr_t'(items.feature_index)
                  * inae_pkg::iw_addr_t'(inae_pkg::HIDDEN_SIZE)
                  + inae_pkg::iw_addr_t'(items.neuron_index);

  always_comb begin
    state_next = state;
    case (state)
      inae_pkg::ST_IDLE: begin
        if (accept) begin
          case (items.mode)
            inae_pkg::MODE_RESET, inae_pkg::MODE_EVAL: state_next = inae_pkg::ST_SWEEP;
            inae_pkg::MODE_ADD, inae_pkg::MODE_REMOVE: begin
              if (feat_ok) begin
                state_next = inae_pkg::ST_SWEEP;
              end
            end
            default: state_next = inae_pkg::ST_IDLE;
          endcase
        end
      end
      inae_pkg::ST_SWEEP: begin
        if (n == inae_pkg::hid_addr_t'(inae_pkg::HIDDEN_SIZE - 1)) begin
          state_next = inae_pkg::ST_DRAIN;
        end
      end
      inae_pkg::ST_DRAIN: begin
        state_next = (op == inae_pkg::MODE_EVAL) ? inae_pkg::ST_TAIL : inae_pkg::ST_IDLE;
      end
      inae_pkg::ST_TAIL: state_next = inae_pkg::ST_FINISH;
      inae_pkg::ST_FINISH: begin
        if (!out_vld || results.ready) begin
          state_next = inae_pkg::ST_IDLE;
        end
      end
      default: state_next = inae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready = state == inae_pkg::ST_IDLE;
    rd_en       = state == inae_pkg::ST_SWEEP;
    out_load    = state == inae_pkg::ST_FINISH && (!out_vld || results.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= inae_pkg::ST_IDLE;
      n        <= '0;
      s1_valid <= 1'b0;
      acc_vld  <= '0;
      out_bias <= '0;
      out_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= rd_en;
      if (rd_en) begin
        n <= n + 1'b1;
      end else begin
        n <= '0;
      end
      if (acc_we) begin
        acc_vld[s1_n] <= 1'b1;
      end
      if (cfg.valid) begin
        out_bias <= cfg.data;
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= items.mode;
      base <= inae_pkg::iw_addr_t'(items.feature_index)
            * inae_pkg::iw_addr_t'(inae_pkg::HIDDEN_SIZE);
    end
    if (rd_en) begin
      s1_n       <= n;
      s1_acc_vld <= acc_vld[n];
    end
    if (out_load) begin
      out_score <= mac_score;
    end
  end

  assign cfg.ready     = 1'b1;
  assign results.valid = out_vld;
  assign results.score = out_score;

  inae_ram #(.WIDTH(inae_pkg::WEIGHT_W), .DEPTH(inae_pkg::IW_DEPTH)) u_iw_ram (
    .clk(clk), .we(iw_we), .waddr(iw_waddr), .wdata(items.weight_value),
    .re(rd_en), .raddr(base + inae_pkg::iw_addr_t'(n)), .rdata(iw_rdata)
  );

  inae_ram #(.WIDTH(inae_pkg::WEIGHT_W), .DEPTH(inae_pkg::HIDDEN_SIZE)) u_hb_ram (
    .clk(clk), .we(hb_we), .waddr(inae_pkg::hid_addr_t'(items.neuron_index)),
    .wdata(items.weight_value), .re(rd_en), .raddr(n), .rdata(hb_rdata)
  );

  inae_ram #(.WIDTH(inae_pkg::WEIGHT_W), .DEPTH(inae_pkg::HIDDEN_SIZE)) u_ow_ram (
    .clk(clk), .we(ow_we), .waddr(inae_pkg::hid_addr_t'(items.neuron_index)),
    .wdata(items.weight_value), .re(rd_en), .raddr(n), .rdata(ow_rdata)
  );

  inae_ram #(.WIDTH(inae_pkg::ACC_W), .DEPTH(inae_pkg::HIDDEN_SIZE)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(s1_n), .wdata(acc_wdata),
    .re(rd_en), .raddr(n), .rdata(acc_rdata)
  );

  assign acc_cur = s1_acc_vld ? acc_rdata : '0;

  always_comb begin
    acc_we    = 1'b0;
    acc_wdata = acc_cur;
    case (op)
      inae_pkg::MODE_RESET: begin
        acc_we    = s1_valid;
        acc_wdata = inae_pkg::sext_w(hb_rdata);
      end
      inae_pkg::MODE_ADD: begin
        acc_we    = s1_valid;
        acc_wdata = acc_cur + inae_pkg::sext_w(iw_rdata);
      end
      inae_pkg::MODE_REMOVE: begin
        acc_we    = s1_valid;
        acc_wdata = acc_cur - inae_pkg::sext_w(iw_rdata);
      end
      default: acc_we = 1'b0;
    endcase
  end

  assign mac_ctrl.clear = accept && items.mode == inae_pkg::MODE_EVAL;
  assign mac_ctrl.step  = s1_valid && op == inae_pkg::MODE_EVAL;

  inae_mac u_mac (
    .clk(clk), .rst(rst), .ctrl(mac_ctrl), .bias(out_bias),
    .acc(acc_cur), .weight(ow_rdata), .score(mac_score)
  );

`ifndef SYNTHESIS
  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    accept |-> !s1_valid)
    else $error("item accepted while the sweep pipeline holds data");

  a_eval_sweeps: assert property (@(posedge clk) disable iff (rst)
    (accept && items.mode == inae_pkg::MODE_EVAL) |=> state == inae_pkg::ST_SWEEP)
    else $error("evaluate item did not start a sweep");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (acc_we && rd_en) |-> s1_n != n)
    else $error("accumulator read and write hit the same entry");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state) == inae_pkg::ST_FINISH)
    else $error("result raised outside the finish step");
`endif

endmodule
